// File: rtl/mlc_pkg.sv
// Shared types, constants and helper functions of the mixing-law layer compaction block.
// Used by the divider, controller, datapath and top level; depends on nothing else.
package mlc_pkg;

    // Divider widths: the widest dividend is a Q.20-shifted 40-bit mass sum.
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 40;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    localparam int SUM_W = 40;
    localparam int CFG_W = 24;
    localparam int CFG_IDX_W = 3;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [30:0] HEIGHT_MAX = 31'h7FFF_FFFF;
    localparam logic [20:0] DEPTH_LIMIT = 21'd1572864;
    localparam logic signed [26:0] KG_PER_G_CM3 = 27'sd1000;

    // Result status codes.
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BAD_DENSITY = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_SLOPE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_CURVE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORG_FLOOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_OFFSET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SLOPE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CURVE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FLOOR = 3'd7;

    // Controller states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_SOLID,
        S_SOLID_WAIT,
        S_ACCUM,
        S_END,
        S_DEPTH,
        S_MUL_DD,
        S_MUL_A1,
        S_MUL_A2,
        S_K1,
        S_MUL_B2,
        S_K2,
        S_DIV1,
        S_DIV1_WAIT,
        S_TERM1,
        S_DIV2,
        S_DIV2_WAIT,
        S_TERM2,
        S_EMPTY,
        S_ERROR,
        S_POR,
        S_POR_WAIT,
        S_POR_SAVE,
        S_FINISH
    } state_t;

    // Datapath commands issued by the controller.
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SOLID_START,
        CMD_ACCUM,
        CMD_DEPTH,
        CMD_MUL_DD,
        CMD_MUL_A1,
        CMD_MUL_A2,
        CMD_K1,
        CMD_MUL_B2,
        CMD_K2,
        CMD_DIV1_START,
        CMD_TERM1,
        CMD_DIV2_START,
        CMD_TERM2,
        CMD_EMPTY,
        CMD_ERROR,
        CMD_POR_START,
        CMD_POR_SAVE,
        CMD_FINISH
    } cmd_t;

    // Status returned from the datapath to the controller.
    typedef struct packed {
        logic use_entry;
        logic last;
        logic err;
        logic empty;
        logic div_done;
        logic out_busy;
    } dp_status_t;

    // Round a Q.20 product back to Q.0 scale: nearest, ties away from zero.
    function automatic logic signed [34:0] rnd20(input logic signed [53:0] x);
        logic [53:0] mag;
        logic [33:0] r;
        begin
            mag = x[53] ? 54'(-x) : 54'(x);
            r = 34'((mag + 54'd524288) >> 20);
            rnd20 = x[53] ? -$signed({1'b0, r}) : $signed({1'b0, r});
        end
    endfunction

    // Saturate a 34-bit signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        begin
            if (v > 34'sd2147483647)
                sat32 = 32'sh7FFF_FFFF;
            else if (v < -34'sd2147483648)
                sat32 = 32'sh8000_0000;
            else
                sat32 = v[31:0];
        end
    endfunction

endpackage

// File: rtl/mlc_divider.sv
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on mlc_pkg for its widths.
module mlc_divider
    import mlc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quot
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] work_reg, work_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    // Shift in one dividend bit and try a subtraction.
    assign trial = {rem_reg, work_reg[DIV_NUM_W-1]};
    assign fits = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        work_next = work_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            work_next = num;
            rem_next = '0;
            den_next = den;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
            work_next = {work_reg[DIV_NUM_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = work_reg;

endmodule

// File: rtl/mlc_ctrl.sv
// Controller state machine: sequences accumulation and layer-end steps.
// Depends on mlc_pkg for the state, command and status types.
module mlc_ctrl
    import mlc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t st,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and command.
    always_comb
    begin
        state_next = state_reg;
        cmd = CMD_NONE;
        in_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd = CMD_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (st.use_entry)
                    state_next = S_SOLID;
                else if (st.last)
                    state_next = S_END;
                else
                    state_next = S_IDLE;
            end
            S_SOLID:
            begin
                cmd = CMD_SOLID_START;
                state_next = S_SOLID_WAIT;
            end
            S_SOLID_WAIT:
            begin
                if (st.div_done)
                    state_next = S_ACCUM;
            end
            S_ACCUM:
            begin
                cmd = CMD_ACCUM;
                state_next = st.last ? S_END : S_IDLE;
            end
            S_END:
            begin
                if (st.err)
                    state_next = S_ERROR;
                else if (st.empty)
                    state_next = S_EMPTY;
                else
                    state_next = S_DEPTH;
            end
            S_DEPTH:
            begin
                cmd = CMD_DEPTH;
                state_next = S_MUL_DD;
            end
            S_MUL_DD:
            begin
                cmd = CMD_MUL_DD;
                state_next = S_MUL_A1;
            end
            S_MUL_A1:
            begin
                cmd = CMD_MUL_A1;
                state_next = S_MUL_A2;
            end
            S_MUL_A2:
            begin
                cmd = CMD_MUL_A2;
                state_next = S_K1;
            end
            S_K1:
            begin
                cmd = CMD_K1;
                state_next = S_MUL_B2;
            end
            S_MUL_B2:
            begin
                cmd = CMD_MUL_B2;
                state_next = S_K2;
            end
            S_K2:
            begin
                cmd = CMD_K2;
                state_next = S_DIV1;
            end
            S_DIV1:
            begin
                cmd = CMD_DIV1_START;
                state_next = S_DIV1_WAIT;
            end
            S_DIV1_WAIT:
            begin
                if (st.div_done)
                    state_next = S_TERM1;
            end
            S_TERM1:
            begin
                cmd = CMD_TERM1;
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                cmd = CMD_DIV2_START;
                state_next = S_DIV2_WAIT;
            end
            S_DIV2_WAIT:
            begin
                if (st.div_done)
                    state_next = S_TERM2;
            end
            S_TERM2:
            begin
                cmd = CMD_TERM2;
                state_next = S_POR;
            end
            S_EMPTY:
            begin
                cmd = CMD_EMPTY;
                state_next = S_POR;
            end
            S_ERROR:
            begin
                cmd = CMD_ERROR;
                state_next = S_FINISH;
            end
            S_POR:
            begin
                cmd = CMD_POR_START;
                state_next = S_POR_WAIT;
            end
            S_POR_WAIT:
            begin
                if (st.div_done)
                    state_next = S_POR_SAVE;
            end
            S_POR_SAVE:
            begin
                cmd = CMD_POR_SAVE;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // Wait until the output register is free.
                if (!st.out_busy)
                begin
                    cmd = CMD_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/mlc_datapath.sv
// Datapath: configuration registers, layer sums, multiplier, divider and output register.
// Depends on mlc_pkg and instantiates mlc_divider.
module mlc_datapath
    import mlc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output dp_status_t           st,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic signed [31:0]   surface_elevation,
    input  logic signed [31:0]   layer_top,
    input  logic [30:0]          layer_height,
    input  logic [31:0]          entry_mass,
    input  logic signed [23:0]   entry_density,
    input  logic                 organic_flag,
    input  logic                 last_entry,
    input  logic                 first_layer,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [30:0]          new_height,
    output logic [16:0]          layer_porosity,
    output logic signed [31:0]   new_top,
    output logic [1:0]           status
);

    // Configuration registers.
    logic signed [23:0] org_offset_reg, org_slope_reg, org_curve_reg;
    logic signed [23:0] min_offset_reg, min_slope_reg, min_curve_reg;
    logic [22:0]        org_floor_reg, min_floor_reg;

    // Latched transaction fields.
    logic signed [31:0] surface_reg, top_reg;
    logic [30:0]        height_reg;
    logic [31:0]        mass_reg;
    logic [22:0]        dens_reg;
    logic               organic_reg, last_reg, use_reg;

    // Layer state.
    logic [SUM_W-1:0]   mass_sum_reg, solid_sum_reg, org_sum_reg;
    logic               err_reg;
    logic signed [31:0] rt_reg;

    // Layer-end working registers.
    logic [20:0]        d_reg;
    logic [21:0]        dd_reg;
    logic signed [53:0] prod_reg;
    logic signed [35:0] k_acc_reg;
    logic [25:0]        k1_reg, k2_reg;
    logic [30:0]        term1_reg, h_reg;
    logic [16:0]        por_reg;
    logic [1:0]         status_reg;

    // Output register.
    logic               out_valid_reg;
    logic [30:0]        out_height_reg;
    logic [16:0]        out_por_reg;
    logic signed [31:0] out_top_reg;
    logic [1:0]         out_status_reg;

    logic signed [26:0]  mul_a, mul_b;
    logic signed [53:0]  mul_p;
    logic signed [34:0]  prod_rnd;
    logic signed [35:0]  k_sum;
    logic signed [33:0]  depth_full;
    logic [SUM_W-1:0]    org_mass, min_mass;
    logic [SUM_W:0]      mass_add, solid_add, org_add;
    logic                div_start, div_done;
    logic [DIV_NUM_W-1:0] div_num, div_quot;
    logic [DIV_DEN_W-1:0] div_den;
    logic signed [SUM_W:0] por_diff;
    logic [31:0]         h_sum;
    logic signed [33:0]  top_sum;
    logic                entry_nonzero, dens_bad;

    // Term of the mixing law from a divider quotient, with its special cases.
    function automatic logic [30:0] term_of(input logic [SUM_W-1:0] m, input logic [25:0] k,
                                            input logic [DIV_NUM_W-1:0] q);
        begin
            if (m == '0)
                term_of = '0;
            else if (k == '0 || q > DIV_NUM_W'(HEIGHT_MAX))
                term_of = HEIGHT_MAX;
            else
                term_of = q[30:0];
        end
    endfunction

    assign entry_nonzero = entry_mass != '0;
    assign dens_bad = entry_density <= 24'sd0;

    assign org_mass = (org_sum_reg > mass_sum_reg) ? mass_sum_reg : org_sum_reg;
    assign min_mass = mass_sum_reg - org_mass;

    // Shared multiplier, operands chosen by the current command.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd)
            CMD_MUL_DD:
            begin
                mul_a = $signed({6'd0, d_reg});
                mul_b = $signed({6'd0, d_reg});
            end
            CMD_MUL_A1:
            begin
                mul_a = 27'(org_slope_reg);
                mul_b = $signed({6'd0, d_reg});
            end
            CMD_MUL_A2:
            begin
                mul_a = 27'(org_curve_reg);
                mul_b = $signed({5'd0, dd_reg});
            end
            CMD_K1:
            begin
                mul_a = 27'(min_slope_reg);
                mul_b = $signed({6'd0, d_reg});
            end
            CMD_MUL_B2:
            begin
                mul_a = 27'(min_curve_reg);
                mul_b = $signed({5'd0, dd_reg});
            end
            CMD_K2:
            begin
                mul_a = $signed({1'b0, k1_reg});
                mul_b = KG_PER_G_CM3;
            end
            CMD_DIV1_START:
            begin
                mul_a = $signed({1'b0, k2_reg});
                mul_b = KG_PER_G_CM3;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign prod_rnd = rnd20(prod_reg);
    assign k_sum = k_acc_reg + 36'(prod_rnd);

    // Mid-layer depth below the surface.
    assign depth_full = 34'(surface_reg) - 34'(top_reg)
                        + 34'($signed({1'b0, height_reg[30:1]}));

    // Divider operands, chosen by the current command.
    assign por_diff = $signed({10'd0, h_reg}) - $signed({1'b0, solid_sum_reg});
    always_comb
    begin
        div_start = 1'b0;
        div_num = '0;
        div_den = '0;
        case (cmd)
            CMD_SOLID_START:
            begin
                div_start = 1'b1;
                div_num = DIV_NUM_W'(mass_reg) + DIV_NUM_W'(dens_reg[22:1]);
                div_den = DIV_DEN_W'(dens_reg);
            end
            CMD_DIV1_START:
            begin
                div_start = 1'b1;
                div_num = DIV_NUM_W'({org_mass, 20'd0}) + DIV_NUM_W'(prod_reg[35:1]);
                div_den = DIV_DEN_W'(prod_reg[35:0]);
            end
            CMD_DIV2_START:
            begin
                div_start = 1'b1;
                div_num = DIV_NUM_W'({min_mass, 20'd0}) + DIV_NUM_W'(prod_reg[35:1]);
                div_den = DIV_DEN_W'(prod_reg[35:0]);
            end
            CMD_POR_START:
            begin
                div_start = 1'b1;
                div_num = DIV_NUM_W'({por_diff[30:0], 16'd0}) + DIV_NUM_W'(h_reg[30:1]);
                div_den = DIV_DEN_W'(h_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    mlc_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign mass_add = {1'b0, mass_sum_reg} + (SUM_W + 1)'(mass_reg);
    assign solid_add = {1'b0, solid_sum_reg} + (SUM_W + 1)'(div_quot[32:0]);
    assign org_add = {1'b0, org_sum_reg} + (SUM_W + 1)'(mass_reg);
    assign h_sum = {1'b0, term1_reg} + {1'b0, term_of(min_mass, k2_reg, div_quot)};
    assign top_sum = 34'(rt_reg) + 34'($signed({1'b0, h_reg}));

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_offset_reg <= 24'sd97071;
            org_slope_reg <= 24'sd36731;
            org_curve_reg <= 24'sd0;
            org_floor_reg <= 23'd20972;
            min_offset_reg <= 24'sd1628000;
            min_slope_reg <= -24'sd393448;
            min_curve_reg <= 24'sd0;
            min_floor_reg <= 23'd209715;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ORG_OFFSET: org_offset_reg <= cfg_data;
                CFG_ORG_SLOPE: org_slope_reg <= cfg_data;
                CFG_ORG_CURVE: org_curve_reg <= cfg_data;
                CFG_ORG_FLOOR: org_floor_reg <= cfg_data[22:0];
                CFG_MIN_OFFSET: min_offset_reg <= cfg_data;
                CFG_MIN_SLOPE: min_slope_reg <= cfg_data;
                CFG_MIN_CURVE: min_curve_reg <= cfg_data;
                CFG_MIN_FLOOR: min_floor_reg <= cfg_data[22:0];
                default: org_floor_reg <= org_floor_reg;
            endcase
        end
    end

    // Layer state, running top and output handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_sum_reg <= '0;
            solid_sum_reg <= '0;
            org_sum_reg <= '0;
            err_reg <= 1'b0;
            rt_reg <= '0;
            use_reg <= 1'b0;
            last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A new result may load in the same cycle the old one is taken.
            if (cmd == CMD_FINISH)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (cmd)
                CMD_LOAD:
                begin
                    last_reg <= last_entry;
                    use_reg <= !err_reg && entry_nonzero && !dens_bad;
                    if (!err_reg && entry_nonzero && dens_bad)
                        err_reg <= 1'b1;
                    if (first_layer)
                        rt_reg <= sat32(34'(layer_top) - 34'($signed({1'b0, layer_height})));
                end
                CMD_ACCUM:
                begin
                    mass_sum_reg <= mass_add[SUM_W] ? SUM_MAX : mass_add[SUM_W-1:0];
                    solid_sum_reg <= solid_add[SUM_W] ? SUM_MAX : solid_add[SUM_W-1:0];
                    if (organic_reg)
                        org_sum_reg <= org_add[SUM_W] ? SUM_MAX : org_add[SUM_W-1:0];
                end
                CMD_FINISH:
                begin
                    rt_reg <= sat32(top_sum);
                    mass_sum_reg <= '0;
                    solid_sum_reg <= '0;
                    org_sum_reg <= '0;
                    err_reg <= 1'b0;
                end
                default:
                begin
                    use_reg <= use_reg;
                end
            endcase
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_LOAD:
            begin
                surface_reg <= surface_elevation;
                top_reg <= layer_top;
                height_reg <= layer_height;
                mass_reg <= entry_mass;
                dens_reg <= entry_density[22:0];
                organic_reg <= organic_flag;
            end
            CMD_DEPTH:
            begin
                if (depth_full < 34'sd0)
                    d_reg <= '0;
                else if (depth_full > 34'($signed({1'b0, DEPTH_LIMIT})))
                    d_reg <= DEPTH_LIMIT;
                else
                    d_reg <= depth_full[20:0];
            end
            CMD_MUL_DD:
            begin
                prod_reg <= mul_p;
            end
            CMD_MUL_A1:
            begin
                dd_reg <= prod_rnd[21:0];
                prod_reg <= mul_p;
            end
            CMD_MUL_A2:
            begin
                k_acc_reg <= 36'(org_offset_reg) + 36'(prod_rnd);
                prod_reg <= mul_p;
            end
            CMD_K1:
            begin
                k1_reg <= (k_sum < $signed({13'd0, org_floor_reg})) ?
                          26'(org_floor_reg) : k_sum[25:0];
                prod_reg <= mul_p;
            end
            CMD_MUL_B2:
            begin
                k_acc_reg <= 36'(min_offset_reg) + 36'(prod_rnd);
                prod_reg <= mul_p;
            end
            CMD_K2:
            begin
                k2_reg <= (k_sum < $signed({13'd0, min_floor_reg})) ?
                          26'(min_floor_reg) : k_sum[25:0];
                prod_reg <= mul_p;
            end
            CMD_DIV1_START:
            begin
                prod_reg <= mul_p;
            end
            CMD_TERM1:
            begin
                term1_reg <= term_of(org_mass, k1_reg, div_quot);
            end
            CMD_TERM2:
            begin
                h_reg <= (h_sum > 32'(HEIGHT_MAX)) ? HEIGHT_MAX : h_sum[30:0];
                status_reg <= ST_OK;
            end
            CMD_EMPTY:
            begin
                h_reg <= height_reg;
                status_reg <= ST_EMPTY;
            end
            CMD_ERROR:
            begin
                h_reg <= '0;
                por_reg <= '0;
                status_reg <= ST_BAD_DENSITY;
            end
            CMD_POR_SAVE:
            begin
                por_reg <= (por_diff > 41'sd0) ? div_quot[16:0] : '0;
            end
            CMD_FINISH:
            begin
                out_height_reg <= h_reg;
                out_por_reg <= por_reg;
                out_top_reg <= sat32(top_sum);
                out_status_reg <= status_reg;
            end
            default:
            begin
                h_reg <= h_reg;
            end
        endcase
    end

    // Status to the controller.
    always_comb
    begin
        st.use_entry = use_reg;
        st.last = last_reg;
        st.err = err_reg;
        st.empty = mass_sum_reg == '0;
        st.div_done = div_done;
        st.out_busy = out_valid_reg && out_stall;
    end

    assign out_valid = out_valid_reg;
    assign new_height = out_height_reg;
    assign layer_porosity = out_por_reg;
    assign new_top = out_top_reg;
    assign status = out_status_reg;

endmodule

// File: rtl/mixing_law_layer_compaction.sv
// Top level of the mixing-law layer compaction block.
// Depends on mlc_pkg, mlc_ctrl and mlc_datapath.
//
// Each transaction carries one material entry of a sediment layer. An entry with
// non-zero mass and positive density, in a layer with no bad density so far, goes
// through the 64-step bit-serial divider that forms its solid volume; other entries skip it.
// The last entry of a layer adds a decision step and seven steps that form the depth and,
// on the shared multiplier, the end-member densities, then three 64-step divisions for
// the two mixing-law terms and the porosity, and a step to load the result; an empty layer
// runs only the porosity division and a bad-density layer none.
// The result waits in an output register, and the next entry is accepted while it
// does; a layer end that finds the previous result still waiting holds until it is taken.
module mixing_law_layer_compaction
    import mlc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [31:0]   surface_elevation,
    input  logic signed [31:0]   layer_top,
    input  logic [30:0]          layer_height,
    input  logic [31:0]          entry_mass,
    input  logic signed [23:0]   entry_density,
    input  logic                 organic_flag,
    input  logic                 last_entry,
    input  logic                 first_layer,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [30:0]          new_height,
    output logic [16:0]          layer_porosity,
    output logic signed [31:0]   new_top,
    output logic [1:0]           status
);

    cmd_t       cmd;
    dp_status_t st;

    // Sequencer.
    mlc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // Arithmetic and storage.
    mlc_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .st                (st),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .surface_elevation (surface_elevation),
        .layer_top         (layer_top),
        .layer_height      (layer_height),
        .entry_mass        (entry_mass),
        .entry_density     (entry_density),
        .organic_flag      (organic_flag),
        .last_entry        (last_entry),
        .first_layer       (first_layer),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .new_height        (new_height),
        .layer_porosity    (layer_porosity),
        .new_top           (new_top),
        .status            (status)
    );

endmodule

// File: tb/tb_mixing_law_layer_compaction.sv
// Self-checking testbench for the mixing-law layer compaction block.
// Depends on mlc_pkg and mixing_law_layer_compaction; predicts each layer result itself.
`timescale 1ns / 100ps

module tb_mixing_law_layer_compaction
    import mlc_pkg::*;
();

    // One material entry as driven on the input channel.
    typedef struct {
        logic signed [31:0] surface;
        logic signed [31:0] top;
        logic [30:0]        height;
        logic [31:0]        mass;
        logic signed [23:0] density;
        logic               organic;
        logic               last;
        logic               first;
    } entry_t;

    // One compacted layer as seen on the output channel.
    typedef struct {
        logic [30:0]        height;
        logic [16:0]        porosity;
        logic signed [31:0] top;
        logic [1:0]         stat;
    } layer_result_t;

    localparam int WATCHDOG_LIMIT = 40000;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic signed [31:0] surface_elevation;
    logic signed [31:0] layer_top;
    logic [30:0] layer_height;
    logic [31:0] entry_mass;
    logic signed [23:0] entry_density;
    logic organic_flag;
    logic last_entry;
    logic first_layer;
    logic out_valid;
    logic out_stall;
    logic [30:0] new_height;
    logic [16:0] layer_porosity;
    logic signed [31:0] new_top;
    logic [1:0] status;

    // Predictor copy of the configuration and layer state.
    longint k1_offset, k1_slope, k1_curve, k1_floor;
    longint k2_offset, k2_slope, k2_curve, k2_floor;
    longint acc_mass, acc_solid, acc_organic, acc_top;
    bit acc_error;

    entry_t pending_entries[$];
    layer_result_t expected_layers[$];
    int send_idle_pct;
    int recv_stall_pct;
    int mismatches;
    int layers_checked;
    int entries_sent;
    int idle_cycles;

    mixing_law_layer_compaction u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .surface_elevation(surface_elevation), .layer_top(layer_top),
        .layer_height(layer_height), .entry_mass(entry_mass),
        .entry_density(entry_density), .organic_flag(organic_flag),
        .last_entry(last_entry), .first_layer(first_layer),
        .out_valid(out_valid), .out_stall(out_stall),
        .new_height(new_height), .layer_porosity(layer_porosity),
        .new_top(new_top), .status(status)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint round_q20(longint x);
        if (x >= 0)
            return (x + 524288) >>> 20;
        return -((-x + 524288) >>> 20);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint add_capped(longint a, longint b, longint hi);
        longint s;
        s = a + b;
        return (s > hi) ? hi : s;
    endfunction

    function automatic longint end_member(longint a0, longint a1, longint a2, longint fl,
                                          longint d);
        longint dd;
        longint k;
        dd = round_q20(d * d);
        k = a0 + round_q20(a1 * d) + round_q20(a2 * dd);
        return (k < fl) ? fl : k;
    endfunction

    function automatic longint thickness_of(longint m, longint k);
        longint unsigned den;
        longint unsigned num;
        if (m == 0)
            return 0;
        if (k <= 0)
            return 64'h7FFFFFFF;
        den = longint'(k) * 1000;
        num = (longint'(m) << 20) + den / 2;
        return longint'(num / den);
    endfunction

    function automatic longint pore_fraction(longint h, longint solid);
        longint unsigned num;
        if (h <= 0 || h <= solid)
            return 0;
        num = (longint'(h - solid) << 16) + longint'(h) / 2;
        return longint'(num / longint'(h));
    endfunction

    // Register write as applied to the predictor copy.
    function automatic void set_coefficient(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
        longint sv;
        sv = longint'($signed(v));
        case (idx)
            CFG_ORG_OFFSET: k1_offset = sv;
            CFG_ORG_SLOPE:  k1_slope = sv;
            CFG_ORG_CURVE:  k1_curve = sv;
            CFG_ORG_FLOOR:  k1_floor = longint'(v[22:0]);
            CFG_MIN_OFFSET: k2_offset = sv;
            CFG_MIN_SLOPE:  k2_slope = sv;
            CFG_MIN_CURVE:  k2_curve = sv;
            CFG_MIN_FLOOR:  k2_floor = longint'(v[22:0]);
            default: ;
        endcase
    endfunction

    // Accumulate one entry and, on the layer's last entry, queue the layer result.
    function automatic void predict_layer(entry_t e);
        longint surf, tp, ht, m, dn, h, por, d, k1, k2, org, mine;
        logic [1:0] st;
        layer_result_t r;
        surf = longint'(e.surface);
        tp = longint'(e.top);
        ht = longint'(e.height);
        m = longint'(e.mass);
        dn = longint'(e.density);
        h = 0;
        por = 0;
        if (e.first)
            acc_top = clamp32(tp - ht);
        if (!acc_error && m > 0)
        begin
            if (dn <= 0)
                acc_error = 1'b1;
            else
            begin
                acc_mass = add_capped(acc_mass, m, 64'hFFFFFFFFFF);
                acc_solid = add_capped(acc_solid, (m + dn / 2) / dn, 64'hFFFFFFFFFF);
                if (e.organic)
                    acc_organic = add_capped(acc_organic, m, 64'hFFFFFFFFFF);
            end
        end
        if (!e.last)
            return;
        if (acc_error)
            st = ST_BAD_DENSITY;
        else if (acc_mass == 0)
        begin
            st = ST_EMPTY;
            h = ht;
            por = pore_fraction(ht, acc_solid);
        end
        else
        begin
            d = surf - (tp - ht / 2);
            if (d < 0)
                d = 0;
            if (d > 1572864)
                d = 1572864;
            k1 = end_member(k1_offset, k1_slope, k1_curve, k1_floor, d);
            k2 = end_member(k2_offset, k2_slope, k2_curve, k2_floor, d);
            org = (acc_organic > acc_mass) ? acc_mass : acc_organic;
            mine = acc_mass - org;
            h = add_capped(thickness_of(org, k1), thickness_of(mine, k2), 64'h7FFFFFFF);
            por = pore_fraction(h, acc_solid);
            st = ST_OK;
        end
        acc_top = clamp32(acc_top + h);
        r.height = h[30:0];
        r.porosity = por[16:0];
        r.top = acc_top[31:0];
        r.stat = st;
        expected_layers.push_back(r);
        acc_mass = 0;
        acc_solid = 0;
        acc_organic = 0;
        acc_error = 1'b0;
    endfunction

    // Driver: presents queued entries and runs the prediction when one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_layer(pending_entries.pop_front());
                entries_sent++;
            end
            if ((!in_valid || !in_stall) && pending_entries.size() > 0
                && !(in_valid && !in_stall && pending_entries.size() == 0))
            begin
                if ((in_valid && !in_stall) || !in_valid)
                begin
                    if ($urandom_range(99) >= send_idle_pct)
                    begin
                        in_valid <= 1'b1;
                        surface_elevation <= pending_entries[0].surface;
                        layer_top <= pending_entries[0].top;
                        layer_height <= pending_entries[0].height;
                        entry_mass <= pending_entries[0].mass;
                        entry_density <= pending_entries[0].density;
                        organic_flag <= pending_entries[0].organic;
                        last_entry <= pending_entries[0].last;
                        first_layer <= pending_entries[0].first;
                    end
                    else
                        in_valid <= 1'b0;
                end
            end
            else if (in_valid && !in_stall)
                in_valid <= 1'b0;
        end
    end

    // Monitor: compares each layer result with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_layers.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected layer result h=%0d por=%0d top=%0d st=%0d",
                             $time, new_height, layer_porosity, new_top, status);
                end
                else
                begin
                    layer_result_t x;
                    x = expected_layers.pop_front();
                    layers_checked++;
                    if (x.height !== new_height || x.porosity !== layer_porosity
                        || x.top !== new_top || x.stat !== status)
                    begin
                        mismatches++;
                        $display("%0t: expected h=%0d por=%0d top=%0d st=%0d", $time,
                                 x.height, x.porosity, x.top, x.stat);
                        $display("%0t: actual   h=%0d por=%0d top=%0d st=%0d", $time,
                                 new_height, layer_porosity, new_top, status);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog over cycles with no accepted transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Random entry; layers are mostly well formed with occasional bad densities.
    function automatic entry_t random_entry(bit last, bit first);
        entry_t e;
        int sel;
        sel = $urandom_range(99);
        e.surface = $urandom_range(3) == 0 ? $urandom() : 32'sd4194304 + $urandom_range(2097152);
        e.top = $urandom_range(3) == 0 ? $urandom() : 32'sd3145728 + $urandom_range(2097152);
        e.height = $urandom_range(4) == 0 ? 31'($urandom()) : 31'($urandom_range(262144));
        if (sel < 10)
            e.mass = 0;
        else if (sel < 20)
            e.mass = $urandom();
        else
            e.mass = $urandom_range(50 << 20);
        if (sel % 17 == 3)
            e.density = -$signed(24'($urandom_range(8388608)));
        else if (sel % 23 == 5)
            e.density = 24'($urandom());
        else
            e.density = 24'(1000 + $urandom_range(2000));
        e.organic = 1'($urandom_range(1));
        e.last = last;
        e.first = first;
        return e;
    endfunction

    function automatic entry_t make_entry(longint surf, longint tp, longint ht, longint m,
                                          longint dn, bit org, bit last, bit first);
        entry_t e;
        e.surface = 32'(surf);
        e.top = 32'(tp);
        e.height = 31'(ht);
        e.mass = 32'(m);
        e.density = 24'(dn);
        e.organic = org;
        e.last = last;
        e.first = first;
        return e;
    endfunction

    task automatic wait_drained();
        while (pending_entries.size() > 0 || in_valid || expected_layers.size() > 0)
        begin
            @(posedge clk);
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("mixing_law_layer_compaction: mismatch");
                $finish;
            end
        end
        repeat (300) @(posedge clk);
    endtask

    // One register write; the enable drops again before the next write.
    task automatic write_coefficient(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        set_coefficient(idx, v);
        @(posedge clk);
    endtask

    task automatic queue_random_layers(int count);
        int n;
        for (int i = 0; i < count; i++)
        begin
            n = $urandom_range(4) == 0 ? 1 : $urandom_range(2, 5);
            for (int j = 0; j < n; j++)
                pending_entries.push_back(random_entry(j == n - 1,
                                                       (i == 0) || ($urandom_range(9) == 0)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        surface_elevation = '0;
        layer_top = '0;
        layer_height = '0;
        entry_mass = '0;
        entry_density = '0;
        organic_flag = 1'b0;
        last_entry = 1'b0;
        first_layer = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatches = 0;
        layers_checked = 0;
        entries_sent = 0;
        idle_cycles = 0;
        k1_offset = 97071;
        k1_slope = 36731;
        k1_curve = 0;
        k1_floor = 20972;
        k2_offset = 1628000;
        k2_slope = -393448;
        k2_curve = 0;
        k2_floor = 209715;
        acc_mass = 0;
        acc_solid = 0;
        acc_organic = 0;
        acc_top = 0;
        acc_error = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed layers: extremes, empty, bad density, zero-mass skip, saturation.
        pending_entries.push_back(make_entry(5242880, 4194304, 1048576, 10 << 20, 2650, 0, 0, 1));
        pending_entries.push_back(make_entry(5242880, 4194304, 1048576, 3 << 20, 1100, 1, 1, 1));
        pending_entries.push_back(make_entry(5242880, 4194304, 1048576, 0, -5, 1, 1, 0));
        pending_entries.push_back(make_entry(0, 0, 2147483647, 0, 0, 0, 1, 0));
        pending_entries.push_back(make_entry(0, 100, 50, 1 << 20, 0, 0, 0, 0));
        pending_entries.push_back(make_entry(0, 100, 50, 1 << 20, 2000, 0, 1, 0));
        pending_entries.push_back(make_entry(0, 100, 50, 1 << 20, -8388608, 1, 1, 0));
        pending_entries.push_back(make_entry(-64'sd2147483648, 2147483647, 2147483647,
                                             32'hFFFFFFFF, 8388607, 1, 0, 1));
        pending_entries.push_back(make_entry(2147483647, -64'sd2147483648, 0, 32'hFFFFFFFF,
                                             1, 0, 1, 0));
        pending_entries.push_back(make_entry(2147483647, 2147483647, 2147483647, 32'hFFFFFFFF,
                                             1, 1, 1, 1));
        pending_entries.push_back(make_entry(2147483647, -64'sd2147483648, 2147483647, 0, 0,
                                             1, 1, 1));
        pending_entries.push_back(make_entry(-64'sd2147483648, -64'sd2147483648, 0, 1, 1,
                                             1, 1, 0));
        wait_drained();

        // Phase sweep over idling patterns and coefficient settings.
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                1: begin send_idle_pct = 67; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 67; end
                3: begin send_idle_pct = 31; recv_stall_pct = 31; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (phase == 1)
            begin
                // Most negative terms; floors at their maxima.
                for (int i = 0; i < 8; i++)
                    write_coefficient(3'(i), (i == 3 || i == 7) ? 24'h7FFFFF : 24'h800000);
            end
            else if (phase == 2)
            begin
                // Largest positive terms, with both floors at zero.
                for (int i = 0; i < 8; i++)
                    write_coefficient(3'(i), (i == 3 || i == 7) ? 24'h0 : 24'h7FFFFF);
            end
            else if (phase >= 3)
            begin
                for (int i = 0; i < 8; i++)
                    write_coefficient(3'(i), 24'($urandom()));
                write_coefficient(CFG_ORG_OFFSET, 24'h0);
                write_coefficient(CFG_ORG_SLOPE, 24'h0);
                write_coefficient(CFG_ORG_CURVE, 24'h0);
                write_coefficient(CFG_ORG_FLOOR, 24'h0);
                if (phase == 4)
                    for (int i = 0; i < 8; i++)
                        write_coefficient(3'(i), 24'($urandom()));
            end
            queue_random_layers(45);
            wait_drained();
        end

        $display("Checked %0d layer results from %0d entries over five idling/config phases.",
                 layers_checked, entries_sent);
        if (mismatches == 0)
            $display("mixing_law_layer_compaction: match");
        else
            $display("mixing_law_layer_compaction: mismatch");
        $finish;
    end

endmodule
